### rtl/core/ray_cylinder_intersect_macros.svh
// Assertion shorthands for the ray/cylinder intersector.
// Expects clk and rst_n in scope; checks are off while reset is low.
`ifndef RAY_CYLINDER_INTERSECT_MACROS_SVH
`define RAY_CYLINDER_INTERSECT_MACROS_SVH
`define RCI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rci: implication check failed");
`define RCI_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rci: forbidden condition seen");
`endif

### rtl/core/rci_pkg.sv
// Shared types, widths, register indexes and latencies of the intersector.
// No dependencies; every other module file imports this package.
`default_nettype none
package rci_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned HIT_W   = 2;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned HH_W    = 31;
  localparam int unsigned EPS_W   = 16;

  localparam int unsigned SQ_W    = 2 * DATA_W;
  localparam int unsigned HSUM_W  = SQ_W + 1;
  localparam int unsigned RAD_W   = 2 * SQ_W;
  localparam int unsigned ROOT_W  = SQ_W;

  localparam int unsigned DIV_MAG_W = HSUM_W + FRAC_W;
  localparam int unsigned DIV_DEN_W = SQ_W;
  localparam int unsigned DIV_Q_W   = DATA_W + 1;

  localparam int unsigned QSIDE_W = 1 + HSUM_W + SQ_W + 2 * DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_H  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 3'd7;

  localparam logic [CFG_W-1:0] RST_ROW0_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] RST_ROW0_HI = 64'h0;
  localparam logic [CFG_W-1:0] RST_ROW1_LO = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW1_HI = 64'h0;
  localparam logic [CFG_W-1:0] RST_ROW2_LO = 64'h0;
  localparam logic [CFG_W-1:0] RST_ROW2_HI = 64'h0000_0000_0001_0000;
  localparam logic [HH_W-1:0]  RST_HALF_H  = 31'h0001_0000;
  localparam logic [EPS_W-1:0] RST_EPS     = 16'd7;

  localparam int unsigned XFORM_LAT = 2;
  localparam int unsigned QUAD_LAT  = 5;
  localparam int unsigned SQRT_LAT  = ROOT_W;
  localparam int unsigned NUM_LAT   = 1;
  localparam int unsigned DIV_LAT   = DIV_Q_W + 2;
  localparam int unsigned HGT_LAT   = 2;
  localparam int unsigned TOTAL_LAT = XFORM_LAT + QUAD_LAT + SQRT_LAT + NUM_LAT
                                      + DIV_LAT + HGT_LAT;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic [HIT_W-1:0]         hit_count;
    logic signed [DATA_W-1:0] t_first;
    logic signed [DATA_W-1:0] t_second;
  } hit_t;

  typedef logic [3:0][DATA_W-1:0] mrow_t;
  typedef mrow_t [2:0] mat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oy;
    logic signed [DATA_W-1:0] oz;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dz;
  } obj_t;

  typedef struct packed {
    logic                     nohit;
    logic signed [HSUM_W-1:0] h;
    logic [SQ_W-1:0]          a;
    logic signed [DATA_W-1:0] oy;
    logic signed [DATA_W-1:0] dy;
  } quad_side_t;

endpackage
`default_nettype wire

### rtl/core/rci_xform.sv
// Two-stage world-to-object transform of ray origin and direction.
// Depends on rci_pkg.
`default_nettype none
module rci_xform (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rci_pkg::ray_t in_ray,
  input  rci_pkg::mat_t mat,
  output logic          out_valid,
  output rci_pkg::obj_t out_obj
);
  import rci_pkg::*;

  localparam int unsigned PRD_W = 2 * DATA_W - FRAC_W;
  localparam int unsigned SUM_W = PRD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  logic signed [DATA_W-1:0]   m [3][4];
  logic signed [DATA_W-1:0]   vo [3];
  logic signed [DATA_W-1:0]   vd [3];
  logic signed [2*DATA_W-1:0] po_full [3][3];
  logic signed [2*DATA_W-1:0] pd_full [3][3];
  logic signed [PRD_W-1:0]    po_r [3][3];
  logic signed [PRD_W-1:0]    pd_r [3][3];
  logic signed [DATA_W-1:0]   tr_r [3];
  logic signed [SUM_W-1:0]    so_nxt [3];
  logic signed [SUM_W-1:0]    sd_nxt [3];
  logic                       v1_r;
  logic                       v2_r;
  obj_t                       obj_nxt;
  obj_t                       obj_r;

  assign vo = '{in_ray.origin_x, in_ray.origin_y, in_ray.origin_z};
  assign vd = '{in_ray.dir_x, in_ray.dir_y, in_ray.dir_z};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = mat[r][c];
      end
      for (int c = 0; c < 3; c++) begin
        po_full[r][c] = m[r][c] * vo[c];
        pd_full[r][c] = m[r][c] * vd[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      so_nxt[r] = SUM_W'(tr_r[r]) + SUM_W'(po_r[r][0]) + SUM_W'(po_r[r][1])
                  + SUM_W'(po_r[r][2]);
      sd_nxt[r] = SUM_W'(pd_r[r][0]) + SUM_W'(pd_r[r][1]) + SUM_W'(pd_r[r][2]);
    end
    obj_nxt.ox = sat32(so_nxt[0]);
    obj_nxt.oy = sat32(so_nxt[1]);
    obj_nxt.oz = sat32(so_nxt[2]);
    obj_nxt.dx = sat32(sd_nxt[0]);
    obj_nxt.dy = sat32(sd_nxt[1]);
    obj_nxt.dz = sat32(sd_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    for (int r = 0; r < 3; r++) begin
      tr_r[r] <= m[r][3];
      for (int c = 0; c < 3; c++) begin
        po_r[r][c] <= po_full[r][c][2*DATA_W-1:FRAC_W];
        pd_r[r][c] <= pd_full[r][c][2*DATA_W-1:FRAC_W];
      end
    end
    obj_r <= obj_nxt;
  end

  assign out_valid = v2_r;
  assign out_obj   = obj_r;

endmodule
`default_nettype wire

### rtl/core/rci_quad.sv
// Quadratic set-up: a, h, c terms and the quarter discriminant over five stages.
// Depends on rci_pkg.
`default_nettype none
module rci_quad (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  rci_pkg::obj_t                in_obj,
  input  logic [rci_pkg::EPS_W-1:0]    eps,
  output logic                         out_valid,
  output logic [rci_pkg::RAD_W-1:0]    out_disc,
  output rci_pkg::quad_side_t          out_side
);
  import rci_pkg::*;

  localparam int unsigned HALF_W = SQ_W / 2;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_W);

  // stage 1: products
  logic signed [SQ_W-1:0] dd0_nxt, dd2_nxt, od0_nxt, od2_nxt, oo0_nxt, oo2_nxt;
  logic signed [SQ_W-1:0] dd0_r, dd2_r, od0_r, od2_r, oo0_r, oo2_r;
  logic signed [DATA_W-1:0] q1_oy_r, q1_dy_r;
  logic q1_vld_r;

  // stage 2: sums
  logic [SQ_W-1:0] a_nxt, csum_nxt, cmag_nxt, hmag_nxt;
  logic signed [HSUM_W-1:0] h_nxt, hneg_nxt;
  logic cneg_nxt;
  quad_side_t q2_side_nxt, q2_side_r;
  logic [SQ_W-1:0] hmag_r, cmag_r;
  logic q2_cneg_r, q2_vld_r;

  // stage 3: partial products
  logic [SQ_W-1:0] sq_l_r, sq_x_r, sq_h_r, ac_ll_r, ac_lh_r, ac_hl_r, ac_hh_r;
  quad_side_t q3_side_r;
  logic q3_cneg_r, q3_vld_r;

  // stage 4: full products
  logic [RAD_W-1:0] hsq_nxt, ac_nxt, hsq_r, ac_r;
  quad_side_t q4_side_r;
  logic q4_cneg_r, q4_vld_r;

  // stage 5: discriminant
  logic [RAD_W-1:0] disc_nxt, disc_r;
  quad_side_t q5_side_nxt, q5_side_r;
  logic q5_vld_r;

  always_comb begin
    dd0_nxt = in_obj.dx * in_obj.dx;
    dd2_nxt = in_obj.dz * in_obj.dz;
    od0_nxt = in_obj.ox * in_obj.dx;
    od2_nxt = in_obj.oz * in_obj.dz;
    oo0_nxt = in_obj.ox * in_obj.ox;
    oo2_nxt = in_obj.oz * in_obj.oz;
  end

  always_comb begin
    a_nxt    = $unsigned(dd0_r) + $unsigned(dd2_r);
    h_nxt    = HSUM_W'(od0_r) + HSUM_W'(od2_r);
    hneg_nxt = -h_nxt;
    hmag_nxt = h_nxt[HSUM_W-1] ? hneg_nxt[SQ_W-1:0] : h_nxt[SQ_W-1:0];
    csum_nxt = $unsigned(oo0_r) + $unsigned(oo2_r);
    cneg_nxt = csum_nxt < ONE_SQ;
    cmag_nxt = cneg_nxt ? ONE_SQ - csum_nxt : csum_nxt - ONE_SQ;
    q2_side_nxt.nohit = (a_nxt == '0) || (a_nxt < (SQ_W'(eps) << FRAC_W));
    q2_side_nxt.h     = h_nxt;
    q2_side_nxt.a     = a_nxt;
    q2_side_nxt.oy    = q1_oy_r;
    q2_side_nxt.dy    = q1_dy_r;
  end

  always_comb begin
    hsq_nxt = {sq_h_r, sq_l_r} + (RAD_W'(sq_x_r) << (HALF_W + 1));
    ac_nxt  = {ac_hh_r, ac_ll_r} + (RAD_W'(ac_lh_r) << HALF_W)
              + (RAD_W'(ac_hl_r) << HALF_W);
  end

  always_comb begin
    disc_nxt          = q4_cneg_r ? hsq_r + ac_r : hsq_r - ac_r;
    q5_side_nxt       = q4_side_r;
    q5_side_nxt.nohit = q4_side_r.nohit || (!q4_cneg_r && (hsq_r < ac_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
      q2_vld_r <= 1'b0;
      q3_vld_r <= 1'b0;
      q4_vld_r <= 1'b0;
      q5_vld_r <= 1'b0;
    end else begin
      q1_vld_r <= in_valid;
      q2_vld_r <= q1_vld_r;
      q3_vld_r <= q2_vld_r;
      q4_vld_r <= q3_vld_r;
      q5_vld_r <= q4_vld_r;
    end
    dd0_r   <= dd0_nxt;
    dd2_r   <= dd2_nxt;
    od0_r   <= od0_nxt;
    od2_r   <= od2_nxt;
    oo0_r   <= oo0_nxt;
    oo2_r   <= oo2_nxt;
    q1_oy_r <= in_obj.oy;
    q1_dy_r <= in_obj.dy;

    q2_side_r <= q2_side_nxt;
    hmag_r    <= hmag_nxt;
    cmag_r    <= cmag_nxt;
    q2_cneg_r <= cneg_nxt;

    sq_l_r    <= hmag_r[HALF_W-1:0] * hmag_r[HALF_W-1:0];
    sq_x_r    <= hmag_r[HALF_W-1:0] * hmag_r[SQ_W-1:HALF_W];
    sq_h_r    <= hmag_r[SQ_W-1:HALF_W] * hmag_r[SQ_W-1:HALF_W];
    ac_ll_r   <= q2_side_r.a[HALF_W-1:0] * cmag_r[HALF_W-1:0];
    ac_lh_r   <= q2_side_r.a[HALF_W-1:0] * cmag_r[SQ_W-1:HALF_W];
    ac_hl_r   <= q2_side_r.a[SQ_W-1:HALF_W] * cmag_r[HALF_W-1:0];
    ac_hh_r   <= q2_side_r.a[SQ_W-1:HALF_W] * cmag_r[SQ_W-1:HALF_W];
    q3_side_r <= q2_side_r;
    q3_cneg_r <= q2_cneg_r;

    hsq_r     <= hsq_nxt;
    ac_r      <= ac_nxt;
    q4_side_r <= q3_side_r;
    q4_cneg_r <= q3_cneg_r;

    disc_r    <= disc_nxt;
    q5_side_r <= q5_side_nxt;
  end

  assign out_valid = q5_vld_r;
  assign out_disc  = disc_r;
  assign out_side  = q5_side_r;

endmodule
`default_nettype wire

### rtl/core/rci_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on rci_pkg.
`default_nettype none
module rci_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rci_pkg::RAD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [rci_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]           out_side
);
  import rci_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 4;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];
  logic              vld_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in, sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in, take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
    assign trial = REM_W'({root_in, 2'b01});
    assign take  = sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= take ? sh - trial : sh;
      root_r[k] <= {root_in[ROOT_W-2:0], take};
      rad_r[k]  <= rad_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule
`default_nettype wire

### rtl/core/rci_div.sv
// Pipelined signed-magnitude divider giving a floored, saturated Q16.16 quotient.
// Depends on rci_pkg; one quotient bit per stage after an overflow check.
`default_nettype none
module rci_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_neg,
  input  logic [rci_pkg::DIV_MAG_W-1:0]   in_mag,
  input  logic [rci_pkg::DIV_DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic signed [rci_pkg::DATA_W-1:0] out_quot,
  output logic [SIDE_W-1:0]               out_side
);
  import rci_pkg::*;

  localparam int unsigned Q_W   = DIV_Q_W;
  localparam int unsigned QQ_W  = Q_W + 1;
  localparam int unsigned REM_W = DIV_DEN_W + 1;
  localparam int unsigned CMP_W = DIV_DEN_W + Q_W;
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic                 pre_vld_r, pre_ovf_r, pre_neg_r;
  logic [REM_W-1:0]     pre_rem_r;
  logic [Q_W-1:0]       pre_low_r;
  logic [DIV_DEN_W-1:0] pre_den_r;
  logic [SIDE_W-1:0]    pre_side_r;

  logic [REM_W-1:0]     rem_r  [Q_W];
  logic [Q_W-1:0]       q_r    [Q_W];
  logic [Q_W-1:0]       low_r  [Q_W];
  logic [DIV_DEN_W-1:0] den_r  [Q_W];
  logic                 ovf_r  [Q_W];
  logic                 neg_r  [Q_W];
  logic [SIDE_W-1:0]    side_r [Q_W];
  logic                 vld_r  [Q_W];

  logic [QQ_W-1:0]      qq;
  logic [DATA_W-1:0]    quot_nxt;
  logic [DATA_W-1:0]    quot_r;
  logic [SIDE_W-1:0]    fin_side_r;
  logic                 fin_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_valid;
    end
    pre_ovf_r  <= CMP_W'(in_mag) >= {in_den, Q_W'(0)};
    pre_neg_r  <= in_neg;
    pre_rem_r  <= REM_W'(in_mag >> Q_W);
    pre_low_r  <= in_mag[Q_W-1:0];
    pre_den_r  <= in_den;
    pre_side_r <= in_side;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [REM_W-1:0]     rem_in, sh;
    logic [Q_W-1:0]       q_in, low_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [SIDE_W-1:0]    side_in;
    logic                 ovf_in, neg_in, vld_in, take;

    if (j == 0) begin : g_first
      assign rem_in  = pre_rem_r;
      assign q_in    = '0;
      assign low_in  = pre_low_r;
      assign den_in  = pre_den_r;
      assign ovf_in  = pre_ovf_r;
      assign neg_in  = pre_neg_r;
      assign side_in = pre_side_r;
      assign vld_in  = pre_vld_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign low_in  = low_r[j-1];
      assign den_in  = den_r[j-1];
      assign ovf_in  = ovf_r[j-1];
      assign neg_in  = neg_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    assign sh   = {rem_in[REM_W-2:0], low_in[Q_W-1-j]};
    assign take = sh >= REM_W'(den_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
      rem_r[j]  <= take ? sh - REM_W'(den_in) : sh;
      q_r[j]    <= {q_in[Q_W-2:0], take};
      low_r[j]  <= low_in;
      den_r[j]  <= den_in;
      ovf_r[j]  <= ovf_in;
      neg_r[j]  <= neg_in;
      side_r[j] <= side_in;
    end
  end

  always_comb begin
    qq = QQ_W'(q_r[Q_W-1]) + QQ_W'(rem_r[Q_W-1] != '0);
    if (!neg_r[Q_W-1]) begin
      if (ovf_r[Q_W-1] || (q_r[Q_W-1] > Q_W'(POS_MAX))) begin
        quot_nxt = POS_MAX;
      end else begin
        quot_nxt = q_r[Q_W-1][DATA_W-1:0];
      end
    end else begin
      if (ovf_r[Q_W-1] || (qq > QQ_W'(NEG_MIN))) begin
        quot_nxt = NEG_MIN;
      end else begin
        quot_nxt = ~qq[DATA_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= vld_r[Q_W-1];
    end
    quot_r     <= quot_nxt;
    fin_side_r <= side_r[Q_W-1];
  end

  assign out_valid = fin_vld_r;
  assign out_quot  = quot_r;
  assign out_side  = fin_side_r;

endmodule
`default_nettype wire

### rtl/core/ray_cylinder_intersect.sv
// Ray against finite unit-radius cylinder: transform, quadratic, root, divide, clip.
// Depends on rci_pkg, rci_xform, rci_quad, rci_isqrt, rci_div and the macro header.
//
//   Channel   Handshake             Beat
//   input     start / busy          in_ray (ray_t)
//   result    out_valid strobe      out_result (hit_t)
//   config    cfg_we                cfg_index, cfg_wdata
//
// One ray enters per clock; busy is always low.
// The pipeline runs through transform, set-up, the 64-stage square root,
// numerator, the 35-stage divider and height stages, in that order.
// Exactly one result per ray; results are never held back, so nothing stalls.
// Synchronous active-low reset clears valid bits and loads the reset registers.
`default_nettype none
`include "ray_cylinder_intersect_macros.svh"
module ray_cylinder_intersect (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rci_pkg::ray_t                   in_ray,
  output logic                            out_valid,
  output rci_pkg::hit_t                   out_result,
  input  logic                            cfg_we,
  input  logic [rci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rci_pkg::CFG_W-1:0]       cfg_wdata
);
  import rci_pkg::*;

  localparam int unsigned NUM_W = HSUM_W + 2;

  logic [CFG_W-1:0] row0_lo_r, row0_hi_r, row1_lo_r, row1_hi_r, row2_lo_r, row2_hi_r;
  logic [HH_W-1:0]  half_h_r;
  logic [EPS_W-1:0] eps_r;
  mat_t             mat;

  logic             xf_vld;
  obj_t             xf_obj;
  logic             qd_vld;
  logic [RAD_W-1:0] qd_disc;
  quad_side_t       qd_side;
  logic             sq_vld;
  logic [ROOT_W-1:0] sq_root;
  quad_side_t       sq_side;

  logic signed [NUM_W-1:0] nh, n0, n1, n0_neg, n1_neg;
  logic [HSUM_W-1:0]       mag0_nxt, mag1_nxt;
  logic                    num_vld_r, num_nohit_r, num_neg0_r, num_neg1_r;
  logic [HSUM_W-1:0]       num_mag0_r, num_mag1_r;
  logic [SQ_W-1:0]         num_den_r;
  logic signed [DATA_W-1:0] num_oy_r, num_dy_r;

  logic                     div0_vld, div1_vld;
  logic signed [DATA_W-1:0] t0, t1;
  logic                     div0_side;
  logic [2*DATA_W-1:0]      div1_side;
  logic signed [DATA_W-1:0] dv_oy, dv_dy;

  logic                     h1_vld_r, h1_nohit_r;
  logic signed [DATA_W-1:0] h1_oy_r, h1_t0_r, h1_t1_r;
  logic signed [SQ_W-1:0]   h1_p0_r, h1_p1_r, p0_nxt, p1_nxt;
  logic signed [SQ_W-1:0]   lim, y0, y1;
  logic                     in0, in1;
  hit_t                     res_nxt, res_r;
  logic                     res_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_lo_r <= RST_ROW0_LO;
      row0_hi_r <= RST_ROW0_HI;
      row1_lo_r <= RST_ROW1_LO;
      row1_hi_r <= RST_ROW1_HI;
      row2_lo_r <= RST_ROW2_LO;
      row2_hi_r <= RST_ROW2_HI;
      half_h_r  <= RST_HALF_H;
      eps_r     <= RST_EPS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW0_LO: row0_lo_r <= cfg_wdata;
        CFG_ROW0_HI: row0_hi_r <= cfg_wdata;
        CFG_ROW1_LO: row1_lo_r <= cfg_wdata;
        CFG_ROW1_HI: row1_hi_r <= cfg_wdata;
        CFG_ROW2_LO: row2_lo_r <= cfg_wdata;
        CFG_ROW2_HI: row2_hi_r <= cfg_wdata;
        CFG_HALF_H:  half_h_r  <= cfg_wdata[HH_W-1:0];
        CFG_EPS:     eps_r     <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign mat[0] = {row0_hi_r, row0_lo_r};
  assign mat[1] = {row1_hi_r, row1_lo_r};
  assign mat[2] = {row2_hi_r, row2_lo_r};

  rci_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_ray   (in_ray),
    .mat      (mat),
    .out_valid(xf_vld),
    .out_obj  (xf_obj)
  );

  rci_quad u_quad (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (xf_vld),
    .in_obj   (xf_obj),
    .eps      (eps_r),
    .out_valid(qd_vld),
    .out_disc (qd_disc),
    .out_side (qd_side)
  );

  rci_isqrt #(
    .SIDE_W(QSIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (qd_vld),
    .in_rad   (qd_disc),
    .in_side  (qd_side),
    .out_valid(sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  always_comb begin
    nh       = -NUM_W'(sq_side.h);
    n0       = nh - $signed(NUM_W'(sq_root));
    n1       = nh + $signed(NUM_W'(sq_root));
    n0_neg   = -n0;
    n1_neg   = -n1;
    mag0_nxt = n0[NUM_W-1] ? n0_neg[HSUM_W-1:0] : n0[HSUM_W-1:0];
    mag1_nxt = n1[NUM_W-1] ? n1_neg[HSUM_W-1:0] : n1[HSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vld_r <= 1'b0;
    end else begin
      num_vld_r <= sq_vld;
    end
    num_nohit_r <= sq_side.nohit;
    num_neg0_r  <= n0[NUM_W-1];
    num_neg1_r  <= n1[NUM_W-1];
    num_mag0_r  <= mag0_nxt;
    num_mag1_r  <= mag1_nxt;
    num_den_r   <= sq_side.a;
    num_oy_r    <= sq_side.oy;
    num_dy_r    <= sq_side.dy;
  end

  rci_div #(
    .SIDE_W(1)
  ) u_div0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (num_vld_r),
    .in_neg   (num_neg0_r),
    .in_mag   ({num_mag0_r, FRAC_W'(0)}),
    .in_den   (num_den_r),
    .in_side  (num_nohit_r),
    .out_valid(div0_vld),
    .out_quot (t0),
    .out_side (div0_side)
  );

  rci_div #(
    .SIDE_W(2 * DATA_W)
  ) u_div1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (num_vld_r),
    .in_neg   (num_neg1_r),
    .in_mag   ({num_mag1_r, FRAC_W'(0)}),
    .in_den   (num_den_r),
    .in_side  ({num_oy_r, num_dy_r}),
    .out_valid(div1_vld),
    .out_quot (t1),
    .out_side (div1_side)
  );

  assign dv_oy  = div1_side[2*DATA_W-1:DATA_W];
  assign dv_dy  = div1_side[DATA_W-1:0];
  assign p0_nxt = t0 * dv_dy;
  assign p1_nxt = t1 * dv_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
    end else begin
      h1_vld_r <= div0_vld && div1_vld;
    end
    h1_nohit_r <= div0_side;
    h1_oy_r    <= dv_oy;
    h1_t0_r    <= t0;
    h1_t1_r    <= t1;
    h1_p0_r    <= p0_nxt;
    h1_p1_r    <= p1_nxt;
  end

  always_comb begin
    lim     = $signed(SQ_W'(half_h_r) << FRAC_W);
    y0      = (SQ_W'(h1_oy_r) <<< FRAC_W) + h1_p0_r;
    y1      = (SQ_W'(h1_oy_r) <<< FRAC_W) + h1_p1_r;
    in0     = (y0 > -lim) && (y0 < lim);
    in1     = (y1 > -lim) && (y1 < lim);
    res_nxt = '0;
    if (!h1_nohit_r) begin
      if (in0) begin
        res_nxt.t_first = h1_t0_r;
        if (in1) begin
          res_nxt.t_second  = h1_t1_r;
          res_nxt.hit_count = 2'd2;
        end else begin
          res_nxt.hit_count = 2'd1;
        end
      end else if (in1) begin
        res_nxt.t_first   = h1_t1_r;
        res_nxt.hit_count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= h1_vld_r;
    end
    res_r <= res_nxt;
  end

  assign out_valid  = res_vld_r;
  assign out_result = res_r;

  `RCI_ASSERT_IMP(a_latency, out_valid, $past(start && !busy, TOTAL_LAT))
  `RCI_ASSERT_IMP(a_div_lockstep, div0_vld || div1_vld, div0_vld && div1_vld)
  `RCI_ASSERT_NEVER(a_count_range, out_valid && (out_result.hit_count == 2'd3))
  `RCI_ASSERT_IMP(a_pack_second, out_valid && (out_result.hit_count != 2'd2), out_result.t_second == '0)
  `RCI_ASSERT_IMP(a_pack_first, out_valid && (out_result.hit_count == 2'd0), out_result.t_first == '0)

endmodule
`default_nettype wire
